// File: sv/neighbor_mean_smoothing_filter_unit_defines.svh
// assertion helpers used by the checker file
`ifndef NEIGHBOR_MEAN_SMOOTHING_FILTER_UNIT_DEFINES_SVH
`define NEIGHBOR_MEAN_SMOOTHING_FILTER_UNIT_DEFINES_SVH

// checked on every edge outside reset
`define NMSF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define NMSF_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/nmsf_pkg.sv
package nmsf_pkg;

   localparam int MAX_LINE_PIXELS = 2048;
   localparam int MAX_LINES       = 4096;

   localparam int COL_W    = 11;
   localparam int ROW_W    = 12;
   localparam int WIDTH_W  = 12;
   localparam int HEIGHT_W = 13;
   localparam int CHAN_W   = 8;
   localparam int ADDR_W   = $clog2(MAX_LINE_PIXELS);

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
   localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_LINE_PIXELS);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_LINES);

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             emit;
   } pos_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      pixel_type         upper;
      pixel_type         middle;
   } mem_wr_type;

   typedef struct packed {
      logic [COL_W-1:0]  center_col;
      logic [ROW_W-1:0]  center_row;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } result_type;

endpackage

// File: sv/nmsf_line_mem.sv
module nmsf_line_mem
   import nmsf_pkg::*;
(
   input  logic              clock,
   input  mem_wr_type        wr,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output pixel_type         rd_upper,
   output pixel_type         rd_middle
);

   // upper line in the high half, middle line in the low half
   logic [2*$bits(pixel_type)-1:0] store_ff [MAX_LINE_PIXELS];
   logic [2*$bits(pixel_type)-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr] <= {wr.upper, wr.middle};
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_upper  = pixel_type'(rd_data_ff[2*$bits(pixel_type)-1:$bits(pixel_type)]);
   assign rd_middle = pixel_type'(rd_data_ff[$bits(pixel_type)-1:0]);

endmodule

// File: sv/nmsf_pos.sv
module nmsf_pos
   import nmsf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [0:0]          csr_index,
   input  logic [HEIGHT_W-1:0] csr_data,
   input  logic                take,
   input  logic                frame_start,
   output pos_type             pos
);

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    row_ff, row_in;

   logic [WIDTH_W-1:0]  width_use;
   logic [HEIGHT_W-1:0] height_use;
   logic [COL_W-1:0]    col_cur;
   logic [ROW_W-1:0]    row_cur;
   logic [WIDTH_W-1:0]  col_inc;
   logic [HEIGHT_W-1:0] row_inc;

   always_comb begin
      width_use = width_ff;
      if (width_ff < WIDTH_MIN) begin
         width_use = WIDTH_MIN;
      end else if (width_ff > WIDTH_MAX) begin
         width_use = WIDTH_MAX;
      end
      height_use = height_ff;
      if (height_ff < HEIGHT_MIN) begin
         height_use = HEIGHT_MIN;
      end else if (height_ff > HEIGHT_MAX) begin
         height_use = HEIGHT_MAX;
      end
   end

   assign col_cur = frame_start ? '0 : col_ff;
   assign row_cur = frame_start ? '0 : row_ff;
   assign col_inc = {1'b0, col_cur} + WIDTH_W'(1);
   assign row_inc = {1'b0, row_cur} + HEIGHT_W'(1);

   // a position past a shrunken limit wraps like the limit itself
   always_comb begin
      if (col_inc >= width_use) begin
         col_in = '0;
         row_in = (row_inc >= height_use) ? '0 : row_inc[ROW_W-1:0];
      end else begin
         col_in = col_inc[COL_W-1:0];
         row_in = ({1'b0, row_cur} >= height_use) ? '0 : row_cur;
      end
   end

   assign pos.col  = col_cur;
   assign pos.row  = row_cur;
   assign pos.emit = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2)) &&
                     ({1'b0, row_cur} < height_use) && ({1'b0, col_cur} < width_use);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_FRAME_WIDTH:  width_ff  <= csr_data[WIDTH_W-1:0];
               CSR_FRAME_HEIGHT: height_ff <= csr_data;
            endcase
         end
         if (take) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

endmodule

// File: sv/nmsf_window.sv
module nmsf_window
   import nmsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  pixel_type  in_pix,
   input  pos_type    in_pos,
   input  pixel_type  rd_upper,
   input  pixel_type  rd_middle,
   output logic       can_take,
   output mem_wr_type wr,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       s1_valid_ff;
   pixel_type  s1_pix_ff;
   pos_type    s1_pos_ff;
   logic       s1_fwd_ff;
   pixel_type  fwd_up_ff;
   pixel_type  fwd_mid_ff;
   pixel_type  win_ff [6];
   logic       out_valid_ff;
   result_type out_ff, out_in;

   pixel_type  up_c, mid_c;
   pixel_type  nb [8];
   logic       out_free, s1_adv;
   logic [CHAN_W+2:0] sum_r, sum_g, sum_b;

   // the line store write of the item leaving now lands at the same edge as the next read
   assign up_c  = s1_fwd_ff ? fwd_up_ff  : rd_upper;
   assign mid_c = s1_fwd_ff ? fwd_mid_ff : rd_middle;

   assign out_free = !out_valid_ff || out_ready;
   assign s1_adv   = s1_valid_ff && (!s1_pos_ff.emit || out_free);
   assign can_take = !s1_valid_ff || s1_adv;

   assign wr.en     = s1_adv;
   assign wr.addr   = s1_pos_ff.col[ADDR_W-1:0];
   assign wr.upper  = mid_c;
   assign wr.middle = s1_pix_ff;

   assign nb[0] = win_ff[0];
   assign nb[1] = win_ff[1];
   assign nb[2] = up_c;
   assign nb[3] = win_ff[2];
   assign nb[4] = mid_c;
   assign nb[5] = win_ff[4];
   assign nb[6] = win_ff[5];
   assign nb[7] = s1_pix_ff;

   always_comb begin
      sum_r = '0;
      sum_g = '0;
      sum_b = '0;
      for (int k = 0; k < 8; k++) begin
         sum_r = sum_r + (CHAN_W+3)'(nb[k].red);
         sum_g = sum_g + (CHAN_W+3)'(nb[k].green);
         sum_b = sum_b + (CHAN_W+3)'(nb[k].blue);
      end
      out_in.red        = sum_r[CHAN_W+2:3];
      out_in.green      = sum_g[CHAN_W+2:3];
      out_in.blue       = sum_b[CHAN_W+2:3];
      out_in.center_row = s1_pos_ff.row - ROW_W'(1);
      out_in.center_col = s1_pos_ff.col - COL_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_fwd_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         if (take) begin
            s1_valid_ff <= 1'b1;
            s1_fwd_ff   <= s1_adv && (in_pos.col == s1_pos_ff.col);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= up_c;
            win_ff[2] <= win_ff[3];
            win_ff[3] <= mid_c;
            win_ff[4] <= win_ff[5];
            win_ff[5] <= s1_pix_ff;
         end
         if (s1_adv && s1_pos_ff.emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_pix_ff  <= in_pix;
         s1_pos_ff  <= in_pos;
         fwd_up_ff  <= mid_c;
         fwd_mid_ff <= s1_pix_ff;
      end
      if (s1_adv && s1_pos_ff.emit) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

// File: sv/neighbor_mean_smoothing_filter_unit.sv
// Eight-neighbor mean smoothing filter for an RGB pixel stream in raster order. Each
// interior pixel yields one item holding the truncated mean of its eight neighbors (center
// left out) for red, green and blue, together with its row and column; border pixels yield
// nothing. The item for a pixel comes out once the pixel below and to its right has arrived.
// The unit takes one pixel every clock unless a stalled result output holds it back; a result
// is held first by the line store read register and then by the output register.
// Two lines are held in one line store memory of 2048 entries that needs no clearing after
// reset. A pixel flagged in tuser as frame start is taken as the top-left pixel of a frame.
// frame_width and frame_height are clamped to 3..2048 and 3..4096 and may be written only
// while the unit is idle.
module neighbor_mean_smoothing_filter_unit
   import nmsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_red, in_green, in_blue
   input  logic [0:0]  req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_red, out_green, out_blue, center_row, center_col, pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_data
);

   logic       take;
   logic       can_take;
   pixel_type  in_pix;
   pos_type    pos;
   mem_wr_type wr;
   pixel_type  rd_upper, rd_middle;
   result_type res;

   assign csr_ready  = 1'b1;
   assign req_tready = can_take;
   assign take       = req_tvalid && can_take;

   assign in_pix.red   = req_tdata[7:0];
   assign in_pix.green = req_tdata[15:8];
   assign in_pix.blue  = req_tdata[23:16];

   nmsf_pos u_pos (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .take        (take),
      .frame_start (req_tuser[0]),
      .pos         (pos)
   );

   nmsf_line_mem u_line_mem (
      .clock     (clock),
      .wr        (wr),
      .rd_en     (take),
      .rd_addr   (pos.col[ADDR_W-1:0]),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle)
   );

   nmsf_window u_window (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .in_pix    (in_pix),
      .in_pos    (pos),
      .rd_upper  (rd_upper),
      .rd_middle (rd_middle),
      .can_take  (can_take),
      .wr        (wr),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   assign rsp_tdata = {1'b0, res};

endmodule

// File: sv/nmsf_check.sv
`include "neighbor_mean_smoothing_filter_unit_defines.svh"

module nmsf_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [0:0]  csr_index,
   input logic [12:0] csr_data
);

   `NMSF_ASSERT(rsp_hold_a, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result item changed while stalled")

   // never a pixel in the first row or the first column
   `NMSF_ASSERT(rsp_interior_a, rsp_tvalid |-> rsp_tdata[35:24] != 12'd0 && rsp_tdata[46:36] != 11'd0, "result for a border pixel")

   // a rising result traces back to an accepted item, through the first stage and the output register
   `NMSF_ASSERT(rsp_latency_a, $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2), "result without a matching item")

   `NMSF_ASSERT_ALWAYS(rsp_reset_a, reset |=> !rsp_tvalid, "result valid right after reset")

endmodule

bind neighbor_mean_smoothing_filter_unit nmsf_check u_nmsf_check (.*);
